@@ rtl/core/cfr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-checked frame receiver package
// Shared types, codes, sizes and the CRC-16 CCITT byte update.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int BUF_DEPTH   = 2 * MAX_PAYLOAD;
  localparam int BUF_AW      = IDX_W + 1;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT     = 2'd2;

  localparam logic [7:0]  MAGIC_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  MAGIC_SECOND_RST = 8'h55;
  localparam logic [15:0] CRC_INIT_RST     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'h1021;
  localparam logic [15:0] CRC_MSB          = 16'h8000;
  localparam logic [15:0] ERR_MAX          = 16'hFFFF;

  typedef enum logic {
    OP_FEED = 1'b0,
    OP_TAKE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_NONE   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PS_MAGIC0  = 3'd0,
    PS_MAGIC1  = 3'd1,
    PS_TYPE    = 3'd2,
    PS_LEN     = 3'd3,
    PS_PAYLOAD = 3'd4,
    PS_CRCLO   = 3'd5,
    PS_CRCHI   = 3'd6
  } parse_t;

  typedef enum logic {
    BK_IDLE   = 1'b0,
    BK_STREAM = 1'b1
  } back_state_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  frame_type;
    logic [6:0]  frame_len;
    logic [7:0]  data_byte;
    logic        last;
    logic        pending;
    logic        frame_accepted;
    logic [15:0] error_count;
  } out_item_t;

  typedef struct packed {
    logic       take;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  magic_first;
    logic [7:0]  magic_second;
    logic [15:0] crc_init;
  } cfg_t;

  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/cfr_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data that holds
// while no read is issued.
// ----------------------------------------------------------------------------
module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/cfr_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Frame receiver front end
// Accepts items, classifies them into feed or take commands and holds them
// in a short queue for the back end.
// ----------------------------------------------------------------------------
module cfr_front import cfr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          cmd_valid,
  input  wire logic     cmd_pop,
  output cmd_t          cmd
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  logic              pop;
  cmd_t              new_cmd;

  assign in_stall  = (cnt_r == QCNT_W'(QDEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    new_cmd.take = (in_item.op == OP_TAKE);
    new_cmd.data = in_item.rx_byte;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/cfr_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Frame receiver back end
// Runs the frame parser and CRC, keeps the pending frame in one of two
// buffer banks, and streams a taken payload through the output register.
// ----------------------------------------------------------------------------
module cfr_back import cfr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cfg_t   cfg,
  input  wire logic   cmd_valid,
  output logic        cmd_pop,
  input  wire cmd_t   cmd,
  output logic        out_valid,
  input  wire logic   out_stall,
  output out_item_t   out_item
);

  back_state_t bk_r, bk_nxt;
  parse_t      parse_r, parse_nxt;
  logic [7:0]  hold_type_r, hold_type_nxt;
  logic [6:0]  hold_len_r, hold_len_nxt;
  logic [6:0]  byte_cnt_r, byte_cnt_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        rx_bank_r, rx_bank_nxt;
  logic        p_bank_r, p_bank_nxt;
  logic [7:0]  p_type_r, p_type_nxt;
  logic [6:0]  p_len_r, p_len_nxt;
  logic        p_flag_r, p_flag_nxt;
  logic [15:0] err_r, err_nxt;
  logic [6:0]  k_r, k_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;

  logic              slot_free;
  logic              last_k;
  logic              feed;
  logic              take;
  logic              acc;
  logic [15:0]       crc_new;
  logic [6:0]        cnt_inc;
  logic              wr_en;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_idx;
  logic [BUF_AW-1:0] wr_addr;
  logic [BUF_AW-1:0] rd_addr;
  logic [7:0]        rd_data;

  function automatic logic [IDX_W-1:0] k_nxt_idx(logic [6:0] k);
    logic [6:0] s;
    s = k + 7'd1;
    return s[IDX_W-1:0];
  endfunction

  assign slot_free = !out_valid_r || !out_stall;
  assign cmd_pop   = cmd_valid && (bk_r == BK_IDLE) && slot_free;
  assign feed      = cmd_pop && !cmd.take;
  assign take      = cmd_pop && cmd.take;
  assign last_k    = ((k_r + 7'd1) == p_len_r);
  assign crc_new   = crc16_step((parse_r == PS_TYPE) ? cfg.crc_init : crc_r, cmd.data);
  assign cnt_inc   = byte_cnt_r + 7'd1;
  assign wr_addr   = {rx_bank_r, byte_cnt_r[IDX_W-1:0]};
  assign rd_addr   = {p_bank_r, rd_idx};
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    bk_nxt = bk_r;
    case (bk_r)
      BK_IDLE: begin
        if (take && p_flag_r && (p_len_r != 7'd0)) begin
          bk_nxt = BK_STREAM;
        end
      end
      BK_STREAM: begin
        if (slot_free && last_k) begin
          bk_nxt = BK_IDLE;
        end
      end
      default: bk_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    parse_nxt     = parse_r;
    hold_type_nxt = hold_type_r;
    hold_len_nxt  = hold_len_r;
    byte_cnt_nxt  = byte_cnt_r;
    crc_lo_nxt    = crc_lo_r;
    crc_nxt       = crc_r;
    rx_bank_nxt   = rx_bank_r;
    p_bank_nxt    = p_bank_r;
    p_type_nxt    = p_type_r;
    p_len_nxt     = p_len_r;
    p_flag_nxt    = p_flag_r;
    err_nxt       = err_r;
    k_nxt         = k_r;
    acc           = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_idx        = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    if (feed) begin
      case (parse_r)
        PS_MAGIC0: begin
          if (cmd.data == cfg.magic_first) begin
            parse_nxt = PS_MAGIC1;
          end
        end
        PS_MAGIC1: begin
          parse_nxt = (cmd.data == cfg.magic_second) ? PS_TYPE : PS_MAGIC0;
        end
        PS_TYPE: begin
          hold_type_nxt = cmd.data;
          crc_nxt       = crc_new;
          parse_nxt     = PS_LEN;
        end
        PS_LEN: begin
          if (cmd.data > 8'(MAX_PAYLOAD)) begin
            err_nxt   = (err_r == ERR_MAX) ? err_r : err_r + 16'd1;
            parse_nxt = PS_MAGIC0;
          end else begin
            hold_len_nxt = cmd.data[6:0];
            byte_cnt_nxt = 7'd0;
            crc_nxt      = crc_new;
            parse_nxt    = (cmd.data == 8'd0) ? PS_CRCLO : PS_PAYLOAD;
          end
        end
        PS_PAYLOAD: begin
          wr_en        = 1'b1;
          crc_nxt      = crc_new;
          byte_cnt_nxt = cnt_inc;
          if (cnt_inc >= hold_len_r) begin
            parse_nxt = PS_CRCLO;
          end
        end
        PS_CRCLO: begin
          crc_lo_nxt = cmd.data;
          parse_nxt  = PS_CRCHI;
        end
        PS_CRCHI: begin
          if (crc_r == {cmd.data, crc_lo_r}) begin
            p_type_nxt  = hold_type_r;
            p_len_nxt   = hold_len_r;
            p_bank_nxt  = rx_bank_r;
            rx_bank_nxt = !rx_bank_r;
            p_flag_nxt  = 1'b1;
            acc         = 1'b1;
          end else begin
            err_nxt = (err_r == ERR_MAX) ? err_r : err_r + 16'd1;
          end
          parse_nxt = PS_MAGIC0;
        end
        default: parse_nxt = PS_MAGIC0;
      endcase
      out_valid_nxt          = 1'b1;
      out_nxt.kind           = KIND_STATUS;
      out_nxt.frame_type     = 8'd0;
      out_nxt.frame_len      = 7'd0;
      out_nxt.data_byte      = 8'd0;
      out_nxt.last           = 1'b1;
      out_nxt.pending        = p_flag_nxt;
      out_nxt.frame_accepted = acc;
      out_nxt.error_count    = err_nxt;
    end else if (take) begin
      out_nxt.frame_accepted = 1'b0;
      out_nxt.error_count    = err_r;
      out_nxt.pending        = 1'b0;
      out_nxt.data_byte      = 8'd0;
      out_nxt.last           = 1'b1;
      if (!p_flag_r) begin
        out_valid_nxt      = 1'b1;
        out_nxt.kind       = KIND_NONE;
        out_nxt.frame_type = 8'd0;
        out_nxt.frame_len  = 7'd0;
      end else begin
        p_flag_nxt = 1'b0;
        if (p_len_r == 7'd0) begin
          out_valid_nxt      = 1'b1;
          out_nxt.kind       = KIND_DATA;
          out_nxt.frame_type = p_type_r;
          out_nxt.frame_len  = 7'd0;
        end else begin
          rd_en  = 1'b1;
          rd_idx = '0;
          k_nxt  = 7'd0;
        end
      end
    end else if ((bk_r == BK_STREAM) && slot_free) begin
      out_valid_nxt          = 1'b1;
      out_nxt.kind           = KIND_DATA;
      out_nxt.frame_type     = p_type_r;
      out_nxt.frame_len      = p_len_r;
      out_nxt.data_byte      = rd_data;
      out_nxt.last           = last_k;
      out_nxt.pending        = 1'b0;
      out_nxt.frame_accepted = 1'b0;
      out_nxt.error_count    = err_r;
      if (!last_k) begin
        rd_en  = 1'b1;
        rd_idx = k_nxt_idx(k_r);
        k_nxt  = k_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bk_r        <= BK_IDLE;
      parse_r     <= PS_MAGIC0;
      hold_type_r <= 8'd0;
      hold_len_r  <= 7'd0;
      byte_cnt_r  <= 7'd0;
      crc_lo_r    <= 8'd0;
      crc_r       <= CRC_INIT_RST;
      rx_bank_r   <= 1'b0;
      p_bank_r    <= 1'b1;
      p_type_r    <= 8'd0;
      p_len_r     <= 7'd0;
      p_flag_r    <= 1'b0;
      err_r       <= 16'd0;
      k_r         <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      bk_r        <= bk_nxt;
      parse_r     <= parse_nxt;
      hold_type_r <= hold_type_nxt;
      hold_len_r  <= hold_len_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      crc_lo_r    <= crc_lo_nxt;
      crc_r       <= crc_nxt;
      rx_bank_r   <= rx_bank_nxt;
      p_bank_r    <= p_bank_nxt;
      p_type_r    <= p_type_nxt;
      p_len_r     <= p_len_nxt;
      p_flag_r    <= p_flag_nxt;
      err_r       <= err_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  cfr_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_buf (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(cmd.data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule
`default_nettype wire

@@ rtl/core/crc_checked_frame_receiver.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-checked frame receiver
// Parses magic, type, length, payload and CRC-16 CCITT from received bytes
// and hands out the latest good frame on request.
//
//   Channel   Handshake            Payload
//   in        in_valid/in_stall    in_item   (op, rx_byte)
//   out       out_valid/out_stall  out_item  (one result per item or byte)
//   cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A fed byte is parsed as the back end pops it; the two-entry command queue
// lets bytes arrive one per cycle while in_stall is low, as the output
// register drains. A take of a frame of length n > 0 gives n results after a
// first read of the payload buffer, one per cycle while out_stall is low;
// an empty take gives one. The back end takes no new command while a
// payload streams out. Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver import cfr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAGIC_FIRST:  cfg_nxt.magic_first  = cfg_data[7:0];
        CFG_MAGIC_SECOND: cfg_nxt.magic_second = cfg_data[7:0];
        CFG_CRC_INIT:     cfg_nxt.crc_init     = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic_first  <= MAGIC_FIRST_RST;
      cfg_r.magic_second <= MAGIC_SECOND_RST;
      cfg_r.crc_init     <= CRC_INIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cfr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd)
  );

  cfr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  a_accept_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.frame_accepted |->
      out_item.pending && (out_item.kind == KIND_STATUS))
    else $error("accepted frame without pending latch");

  a_data_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.kind == KIND_DATA) |-> !out_item.pending)
    else $error("payload byte shown with pending latch set");

  a_none_is_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.kind == KIND_NONE) |->
      out_item.last && (out_item.frame_len == 7'd0))
    else $error("empty take result malformed");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid && !(out_valid && out_stall))
    else $error("command taken while output blocked");

endmodule
`default_nettype wire
